/* rtl/chas_pkg.sv */
// Package for the convex hull angle share core: sizes, fixed-point formats
// and the CORDIC arctangent table. No dependencies.
package chas_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 21;

    localparam int PT_AW   = $clog2(MAX_POINTS);
    localparam int CNT_W   = PT_AW + 1;
    localparam int HULL_AW = PT_AW + 1;
    localparam int K_W     = HULL_AW + 1;

    localparam int IDX_W   = 6;
    localparam int SHARE_W = 32;
    localparam int ANG_W   = 32;

    // operand widths of the shared multiplier pair; keep +2^SHR_EXP representable
    localparam int DIF_W   = COORD_BITS + 1;
    localparam int SHR_EXP = 29;
    localparam int OP_W    = (DIF_W > SHR_EXP + 1) ? DIF_W : SHR_EXP + 2;
    localparam int PROD_W  = 2 * OP_W;

    // CORDIC datapath
    localparam int CW      = PROD_W + 3;
    localparam int ZW      = ANG_W + 2;
    localparam int STEPS   = 31;
    localparam int STEP_W  = 5;

    // share division
    localparam int TOT_W   = ANG_W + PT_AW;
    localparam int QW      = 32;
    localparam int FRAC    = ANG_W - 1;
    localparam int NUM_W   = ANG_W + FRAC + 1;

    localparam logic [ANG_W-1:0] ANG_PI      = 32'h8000_0000;
    localparam logic [ZW-1:0]    Z_HALF_PI   = ZW'(32'h4000_0000);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [OP_W-1:0]       t_op;

    // atan(2^-s) with 2^31 = pi
    function automatic logic [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] s);
        logic [ANG_W-1:0] v;
        case (s)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/chas_pt_if.sv */
// Point input channel of the convex hull angle share core.
// Depends on chas_pkg for the coordinate type.
interface chas_pt_if;
    import chas_pkg::*;
    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    logic   last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

/* rtl/chas_sh_if.sv */
// Share result channel of the convex hull angle share core.
// Depends on chas_pkg for field widths.
interface chas_sh_if;
    import chas_pkg::*;
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   point_index;
    logic [SHARE_W-1:0] share;
    logic               last_share;

    modport source (output valid, point_index, share, last_share, input ready);
    modport sink   (input valid, point_index, share, last_share, output ready);
endinterface

/* rtl/convex_hull_angle_share_core.sv */
// Convex hull exterior angle share core: load, sort, hull scan, CORDIC, divide.
// Depends on chas_pkg, chas_pt_if and chas_sh_if.
//
// Usage: points enter on i_pt, one per cycle while i_pt.ready is high; the
// item with last_point set closes the set (points past MAX_POINTS are dropped,
// their last mark still counts). Then i_pt.ready stays low while the core
// works and sends one item per stored point on o_sh, in input order, with
// last_share on the final one.
// Work runs out of four memories (points, sort order, hull stack, angles),
// each with one write port and one registered read port:
//   sort   : rank count, one point read a cycle
//   hull   : 2n-1 pushes, each after popping the points that fail the turn test
//   angles : stack search and a 31-step CORDIC per point, one step a cycle
//   output : 32-step restoring divide per item
// A single point is answered the cycle after it arrives.
// Reset (i_rst_n low, synchronous) drops any set in progress and returns to
// loading. A stalled o_sh holds the pending item and freezes the core.
module convex_hull_angle_share_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    chas_pt_if.sink         i_pt,
    chas_sh_if.source       o_sh
);
    import chas_pkg::*;

    localparam logic [4:0] ST_LOAD    = 5'd0;
    localparam logic [4:0] ST_SORT_I  = 5'd1;
    localparam logic [4:0] ST_SORT_I2 = 5'd2;
    localparam logic [4:0] ST_SORT_J  = 5'd3;
    localparam logic [4:0] ST_SORT_W  = 5'd4;
    localparam logic [4:0] ST_H_ORD   = 5'd5;
    localparam logic [4:0] ST_H_PT    = 5'd6;
    localparam logic [4:0] ST_H_PT2   = 5'd7;
    localparam logic [4:0] ST_H_TEST  = 5'd8;
    localparam logic [4:0] ST_H_RO    = 5'd9;
    localparam logic [4:0] ST_H_RM    = 5'd10;
    localparam logic [4:0] ST_H_CR    = 5'd11;
    localparam logic [4:0] ST_H_PUSH  = 5'd12;
    localparam logic [4:0] ST_A_PT    = 5'd13;
    localparam logic [4:0] ST_A_PT2   = 5'd14;
    localparam logic [4:0] ST_A_SRCH  = 5'd15;
    localparam logic [4:0] ST_A_L     = 5'd16;
    localparam logic [4:0] ST_A_R     = 5'd17;
    localparam logic [4:0] ST_A_SHR   = 5'd18;
    localparam logic [4:0] ST_A_M1    = 5'd19;
    localparam logic [4:0] ST_A_M2    = 5'd20;
    localparam logic [4:0] ST_A_M3    = 5'd21;
    localparam logic [4:0] ST_A_COR   = 5'd22;
    localparam logic [4:0] ST_A_FIN   = 5'd23;
    localparam logic [4:0] ST_A_WR    = 5'd24;
    localparam logic [4:0] ST_O_RD    = 5'd25;
    localparam logic [4:0] ST_O_DIV0  = 5'd26;
    localparam logic [4:0] ST_O_DIV   = 5'd27;
    localparam logic [4:0] ST_O_OUT   = 5'd28;
    localparam logic [4:0] ST_O_WAIT  = 5'd29;

    localparam int  PW = 2 * COORD_BITS;
    localparam t_op SHR_HI = t_op'(64'sd1 <<< SHR_EXP);
    localparam t_op SHR_LO = -SHR_HI;

    // control
    logic [4:0]          r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_i;
    logic [HULL_AW-1:0]  r_j;
    logic [PT_AW-1:0]    r_rank;
    logic [K_W-1:0]      r_k;
    logic [K_W-1:0]      r_t;
    logic [K_W-1:0]      r_h;
    logic                r_pass;
    logic [STEP_W-1:0]   r_step;
    logic                r_ov;

    // datapath
    t_coord              r_px, r_py, r_ox, r_oy;
    t_op                 r_ux, r_uy, r_vx, r_vy;
    logic signed [PROD_W-1:0] r_prod0, r_prod1;
    logic signed [CW-1:0]     r_cx, r_cy;
    logic signed [ZW-1:0]     r_z;
    logic [ANG_W-1:0]    r_ang;
    logic [TOT_W-1:0]    r_total;
    logic [TOT_W-1:0]    r_rem;
    logic [QW-1:0]       r_quo;
    logic [IDX_W-1:0]    r_o_idx;
    logic [SHARE_W-1:0]  r_o_share;
    logic                r_o_last;

    // memories
    logic [PW-1:0]       mem_pt   [MAX_POINTS];
    logic [PT_AW-1:0]    mem_ord  [MAX_POINTS];
    logic [PW-1:0]       mem_hull [2*MAX_POINTS];
    logic [ANG_W-1:0]    mem_ang  [MAX_POINTS];
    logic [PW-1:0]       r_pt_rd, r_hull_rd;
    logic [PT_AW-1:0]    r_ord_rd;
    logic [ANG_W-1:0]    r_ang_rd;

    logic                pt_we, ord_we, hull_we, ang_we;
    logic [PT_AW-1:0]    pt_ra, ord_ra, ang_ra;
    logic [HULL_AW-1:0]  hull_ra;

    always_ff @(posedge i_clk) begin
        if (pt_we) mem_pt[r_cnt[PT_AW-1:0]] <= {i_pt.point_x, i_pt.point_y};
        r_pt_rd <= mem_pt[pt_ra];
    end
    always_ff @(posedge i_clk) begin
        if (ord_we) mem_ord[r_rank] <= r_i[PT_AW-1:0];
        r_ord_rd <= mem_ord[ord_ra];
    end
    always_ff @(posedge i_clk) begin
        if (hull_we) mem_hull[r_k[HULL_AW-1:0]] <= {r_px, r_py};
        r_hull_rd <= mem_hull[hull_ra];
    end
    always_ff @(posedge i_clk) begin
        if (ang_we) mem_ang[r_i[PT_AW-1:0]] <= r_ang;
        r_ang_rd <= mem_ang[ang_ra];
    end

    // read data views
    t_coord pt_x, pt_y, hx, hy;
    assign pt_x = r_pt_rd[PW-1:COORD_BITS];
    assign pt_y = r_pt_rd[COORD_BITS-1:0];
    assign hx   = r_hull_rd[PW-1:COORD_BITS];
    assign hy   = r_hull_rd[COORD_BITS-1:0];

    logic [CNT_W-1:0]   n_cnt;
    logic [CNT_W-1:0]   n_m1;
    logic [K_W-1:0]     k_m1, k_m2, h_m1;
    logic [HULL_AW-1:0] jl, jr, j_p1;
    logic               sort_before;
    logic               hull_hit;
    logic               need_u, need_v;

    assign n_cnt = (r_cnt < CNT_W'(MAX_POINTS)) ? r_cnt + 1'b1 : r_cnt;
    assign n_m1  = r_n - 1'b1;
    assign k_m1  = r_k - 1'b1;
    assign k_m2  = r_k - K_W'(2);
    assign h_m1  = r_h - 1'b1;
    assign j_p1  = r_j + 1'b1;
    assign jl    = (r_j == '0) ? h_m1[HULL_AW-1:0] : r_j - 1'b1;
    assign jr    = (K_W'(j_p1) == r_h) ? '0 : j_p1;

    // stable order: equal keys rank by input position
    assign sort_before = (pt_x < r_px) ||
                         ((pt_x == r_px) && ((pt_y < r_py) ||
                          ((pt_y == r_py) && (CNT_W'(r_j) < r_i))));
    assign hull_hit = (hx == r_px) && (hy == r_py);
    assign need_u = (r_ux >= SHR_HI) || (r_ux <= SHR_LO) ||
                    (r_uy >= SHR_HI) || (r_uy <= SHR_LO);
    assign need_v = (r_vx >= SHR_HI) || (r_vx <= SHR_LO) ||
                    (r_vy >= SHR_HI) || (r_vy <= SHR_LO);

    // coordinate differences for the hull turn test and the angle vectors
    logic signed [DIF_W-1:0] d_a, d_b, d_c, d_d, d_ux, d_uy;
    assign d_a  = DIF_W'(hx) - DIF_W'(r_ox);
    assign d_b  = DIF_W'(hy) - DIF_W'(r_oy);
    assign d_c  = DIF_W'(r_px) - DIF_W'(hx);
    assign d_d  = DIF_W'(r_py) - DIF_W'(hy);
    assign d_ux = DIF_W'(hx) - DIF_W'(r_px);
    assign d_uy = DIF_W'(hy) - DIF_W'(r_py);

    // shared multiplier pair
    t_op mul_a0, mul_b0, mul_a1, mul_b1;
    logic signed [PROD_W-1:0] mul_p0, mul_p1;
    always_comb begin
        mul_a0 = r_ux;
        mul_b0 = r_vx;
        mul_a1 = r_uy;
        mul_b1 = r_vy;
        case (r_state)
            ST_H_RM: begin
                mul_a0 = OP_W'(d_a);
                mul_b0 = OP_W'(d_d);
                mul_a1 = OP_W'(d_b);
                mul_b1 = OP_W'(d_c);
            end
            ST_A_M2: begin
                mul_b0 = r_vy;
                mul_b1 = r_vx;
            end
            default: ;
        endcase
    end
    assign mul_p0 = mul_a0 * mul_b0;
    assign mul_p1 = mul_a1 * mul_b1;

    logic signed [PROD_W:0]  cross_h;
    logic signed [CW-1:0]    cr_y, cr_ya, cor_xs, cor_ys;
    logic [NUM_W-1:0]        div_num;
    logic [TOT_W:0]          div_trial;
    logic                    div_ge;
    assign cross_h   = (PROD_W+1)'(r_prod0) - (PROD_W+1)'(r_prod1);
    assign cr_y      = CW'(r_prod0) - CW'(r_prod1);
    assign cr_ya     = cr_y[CW-1] ? -cr_y : cr_y;
    assign cor_xs    = r_cx >>> r_step;
    assign cor_ys    = r_cy >>> r_step;
    assign div_num   = (NUM_W'(r_ang_rd) << FRAC) + NUM_W'(r_total >> 1);
    assign div_trial = {r_rem, r_quo[QW-1]};
    assign div_ge    = div_trial >= {1'b0, r_total};

    // memory control
    always_comb begin
        pt_we   = 1'b0;
        ord_we  = 1'b0;
        hull_we = 1'b0;
        ang_we  = 1'b0;
        pt_ra   = r_i[PT_AW-1:0];
        ord_ra  = r_i[PT_AW-1:0];
        ang_ra  = r_i[PT_AW-1:0];
        hull_ra = '0;
        case (r_state)
            ST_LOAD:    pt_we = i_pt.valid && (r_cnt < CNT_W'(MAX_POINTS));
            ST_SORT_I2: pt_ra = '0;
            ST_SORT_J:  pt_ra = j_p1[PT_AW-1:0];
            ST_SORT_W:  ord_we = 1'b1;
            ST_H_PT:    pt_ra = r_ord_rd;
            ST_H_TEST:  hull_ra = k_m2[HULL_AW-1:0];
            ST_H_RO:    hull_ra = k_m1[HULL_AW-1:0];
            ST_H_PUSH:  hull_we = 1'b1;
            ST_A_SRCH:  hull_ra = hull_hit ? jl : j_p1;
            ST_A_L:     hull_ra = jr;
            ST_A_WR:    ang_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_k     <= '0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (i_pt.valid) begin
                        r_cnt <= n_cnt;
                        if (i_pt.last_point) begin
                            r_cnt <= '0;
                            r_n   <= n_cnt;
                            r_i   <= '0;
                            if (n_cnt == CNT_W'(1)) begin
                                r_o_idx   <= '0;
                                r_o_share <= ANG_PI;
                                r_o_last  <= 1'b1;
                                r_ov      <= 1'b1;
                                r_state   <= ST_O_WAIT;
                            end else begin
                                r_state <= ST_SORT_I;
                            end
                        end
                    end
                end
                ST_SORT_I: r_state <= ST_SORT_I2;
                ST_SORT_I2: begin
                    r_px    <= pt_x;
                    r_py    <= pt_y;
                    r_j     <= '0;
                    r_rank  <= '0;
                    r_state <= ST_SORT_J;
                end
                ST_SORT_J: begin
                    if (sort_before) r_rank <= r_rank + 1'b1;
                    if (CNT_W'(r_j) == n_m1) r_state <= ST_SORT_W;
                    else r_j <= j_p1;
                end
                ST_SORT_W: begin
                    if (r_i == n_m1) begin
                        r_i    <= '0;
                        r_k    <= '0;
                        r_pass <= 1'b0;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                    r_state <= (r_i == n_m1) ? ST_H_ORD : ST_SORT_I;
                end
                ST_H_ORD: r_state <= ST_H_PT;
                ST_H_PT:  r_state <= ST_H_PT2;
                ST_H_PT2: begin
                    r_px    <= pt_x;
                    r_py    <= pt_y;
                    r_state <= ST_H_TEST;
                end
                ST_H_TEST: begin
                    if (r_k > (r_pass ? r_t : K_W'(1))) r_state <= ST_H_RO;
                    else r_state <= ST_H_PUSH;
                end
                ST_H_RO: begin
                    r_ox    <= hx;
                    r_oy    <= hy;
                    r_state <= ST_H_RM;
                end
                ST_H_RM: begin
                    r_prod0 <= mul_p0;
                    r_prod1 <= mul_p1;
                    r_state <= ST_H_CR;
                end
                ST_H_CR: begin
                    // drop the middle point on a clockwise or straight turn
                    if (cross_h[PROD_W] || (cross_h == '0)) begin
                        r_k     <= k_m1;
                        r_state <= ST_H_TEST;
                    end else begin
                        r_state <= ST_H_PUSH;
                    end
                end
                ST_H_PUSH: begin
                    r_k     <= r_k + 1'b1;
                    r_state <= ST_H_ORD;
                    if (!r_pass) begin
                        if (r_i == n_m1) begin
                            r_t    <= r_k + 1'b1;
                            r_pass <= 1'b1;
                            r_i    <= r_n - CNT_W'(2);
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else if (r_i == '0) begin
                        r_h     <= r_k;
                        r_total <= '0;
                        r_state <= ST_A_PT;
                    end else begin
                        r_i <= r_i - 1'b1;
                    end
                end
                ST_A_PT: r_state <= ST_A_PT2;
                ST_A_PT2: begin
                    r_px    <= pt_x;
                    r_py    <= pt_y;
                    r_j     <= '0;
                    r_state <= ST_A_SRCH;
                end
                ST_A_SRCH: begin
                    if (hull_hit) begin
                        r_state <= ST_A_L;
                    end else if (K_W'(r_j) == h_m1) begin
                        r_ang   <= '0;
                        r_state <= ST_A_WR;
                    end else begin
                        r_j <= j_p1;
                    end
                end
                ST_A_L: begin
                    r_ux    <= OP_W'(d_ux);
                    r_uy    <= OP_W'(d_uy);
                    r_state <= ST_A_R;
                end
                ST_A_R: begin
                    r_vx    <= OP_W'(d_ux);
                    r_vy    <= OP_W'(d_uy);
                    r_state <= ST_A_SHR;
                end
                ST_A_SHR: begin
                    if (need_u) begin
                        r_ux <= r_ux >>> 1;
                        r_uy <= r_uy >>> 1;
                    end
                    if (need_v) begin
                        r_vx <= r_vx >>> 1;
                        r_vy <= r_vy >>> 1;
                    end
                    if (!need_u && !need_v) r_state <= ST_A_M1;
                end
                ST_A_M1: begin
                    r_prod0 <= mul_p0;
                    r_prod1 <= mul_p1;
                    r_state <= ST_A_M2;
                end
                ST_A_M2: begin
                    r_cx    <= CW'(r_prod0) + CW'(r_prod1);
                    r_prod0 <= mul_p0;
                    r_prod1 <= mul_p1;
                    r_state <= ST_A_M3;
                end
                ST_A_M3: begin
                    r_step <= '0;
                    if (cr_ya == '0) begin
                        r_ang   <= r_cx[CW-1] ? '0 : ANG_PI;
                        r_state <= ST_A_WR;
                    end else begin
                        // rotate an obtuse vector by a quarter turn first
                        if (r_cx[CW-1]) begin
                            r_cx <= cr_ya;
                            r_cy <= -r_cx;
                            r_z  <= Z_HALF_PI;
                        end else begin
                            r_cy <= cr_ya;
                            r_z  <= '0;
                        end
                        r_state <= ST_A_COR;
                    end
                end
                ST_A_COR: begin
                    if (!r_cy[CW-1]) begin
                        r_cx <= r_cx + cor_ys;
                        r_cy <= r_cy - cor_xs;
                        r_z  <= r_z + ZW'(atan_step(r_step));
                    end else begin
                        r_cx <= r_cx - cor_ys;
                        r_cy <= r_cy + cor_xs;
                        r_z  <= r_z - ZW'(atan_step(r_step));
                    end
                    if (r_step == STEP_W'(STEPS - 1)) r_state <= ST_A_FIN;
                    else r_step <= r_step + 1'b1;
                end
                ST_A_FIN: begin
                    if (r_z[ZW-1]) r_ang <= ANG_PI;
                    else if (r_z > ZW'(ANG_PI)) r_ang <= '0;
                    else r_ang <= ANG_W'(ZW'(ANG_PI) - r_z);
                    r_state <= ST_A_WR;
                end
                ST_A_WR: begin
                    r_total <= r_total + TOT_W'(r_ang);
                    if (r_i == n_m1) begin
                        r_i     <= '0;
                        r_state <= ST_O_RD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_A_PT;
                    end
                end
                ST_O_RD: r_state <= ST_O_DIV0;
                ST_O_DIV0: begin
                    r_rem   <= TOT_W'(div_num[NUM_W-1:QW]);
                    r_quo   <= div_num[QW-1:0];
                    r_step  <= '0;
                    r_state <= ST_O_DIV;
                end
                ST_O_DIV: begin
                    r_rem <= div_ge ? TOT_W'(div_trial - {1'b0, r_total})
                                    : TOT_W'(div_trial);
                    r_quo <= {r_quo[QW-2:0], div_ge};
                    if (r_step == STEP_W'(QW - 1)) r_state <= ST_O_OUT;
                    else r_step <= r_step + 1'b1;
                end
                ST_O_OUT: begin
                    if (r_total == '0) r_o_share <= '0;
                    else if (r_quo > ANG_PI) r_o_share <= ANG_PI;
                    else r_o_share <= r_quo;
                    r_o_idx  <= IDX_W'(r_i[PT_AW-1:0]);
                    r_o_last <= (r_i == n_m1);
                    r_ov     <= 1'b1;
                    r_state  <= ST_O_WAIT;
                end
                ST_O_WAIT: begin
                    if (o_sh.ready) begin
                        r_ov <= 1'b0;
                        if (r_i == n_m1) begin
                            r_state <= ST_LOAD;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= ST_O_RD;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign i_pt.ready       = (r_state == ST_LOAD);
    assign o_sh.valid       = r_ov;
    assign o_sh.point_index = r_o_idx;
    assign o_sh.share       = r_o_share;
    assign o_sh.last_share  = r_o_last;

    a_no_load_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pt.ready |-> !o_sh.valid)
        else $error("point accepted while a share item is pending");

    a_share_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sh.valid |-> (o_sh.share <= ANG_PI))
        else $error("share above one");

    a_last_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sh.valid |-> (o_sh.last_share == (CNT_W'(o_sh.point_index) == n_m1)))
        else $error("last_share does not match the set size");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= K_W'(2 * MAX_POINTS))
        else $error("hull stack overflow");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pt.valid && i_pt.ready && i_pt.last_point) |=> !i_pt.ready)
        else $error("core still loading after the last point");

endmodule

/* tb/convex_hull_angle_share_core_test.sv */
// Testbench for convex_hull_angle_share_core: drives point sets, predicts the
// hull angle shares of every set and checks each share item in order.
// Depends on chas_pkg, chas_pt_if, chas_sh_if and the core itself.

typedef struct {
    logic [chas_pkg::IDX_W-1:0]   idx;
    logic [chas_pkg::SHARE_W-1:0] share;
    logic                         last;
} share_item_t;

class hull_share_board;
    longint      pt_x[64];
    longint      pt_y[64];
    int          order[64];
    int          stack_q[128];
    longint      vtx_angle[64];
    int          n_stored;
    int          errors;
    share_item_t pending[$];
    longint      atan_lut[31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1};

    function new();
        n_stored = 0;
        errors   = 0;
    endfunction

    // append one expected item
    function void add_expected(share_item_t it);
        pending = {pending, it};
    endfunction

    function int turn_sign(int o, int m, int p);
        longint a, b, c, d, v;
        a = pt_x[m] - pt_x[o];
        b = pt_y[m] - pt_y[o];
        c = pt_x[p] - pt_x[m];
        d = pt_y[p] - pt_y[m];
        v = a * d - b * c;
        return (v < 0) ? -1 : ((v > 0) ? 1 : 0);
    endfunction

    function bit precedes(int i, int j);
        if (pt_x[i] != pt_x[j]) return pt_x[i] < pt_x[j];
        return pt_y[i] < pt_y[j];
    endfunction

    function void narrow(ref longint a, ref longint b);
        for (int g = 0; g < 64; g++) begin
            if ((a < 0 ? -a : a) < (64'sd1 <<< 29) && (b < 0 ? -b : b) < (64'sd1 <<< 29))
                break;
            a = a >>> 1;
            b = b >>> 1;
        end
    endfunction

    // exterior angle at c, 2^31 = pi
    function longint ext_angle(int c, int l, int r);
        longint ux, uy, vx, vy, x, y, z, t, xs, ys;
        ux = pt_x[l] - pt_x[c];
        uy = pt_y[l] - pt_y[c];
        vx = pt_x[r] - pt_x[c];
        vy = pt_y[r] - pt_y[c];
        z = 0;
        narrow(ux, uy);
        narrow(vx, vy);
        x = ux * vx + uy * vy;
        y = ux * vy - uy * vx;
        if (y < 0) y = -y;
        if (y == 0) return (x >= 0) ? 64'sh8000_0000 : 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = 64'sd1 <<< 30;
        end
        for (int i = 0; i < 31; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += atan_lut[i];
            end else begin
                x -= ys;
                y += xs;
                z -= atan_lut[i];
            end
        end
        if (z < 0) z = 0;
        if (z > (64'sd1 <<< 31)) z = 64'sd1 <<< 31;
        return (64'sd1 <<< 31) - z;
    endfunction

    function void build_hull(int n);
        int j, k, t, h, v, p;
        for (int i = 0; i < n; i++) order[i] = i;
        for (int i = 1; i < n; i++) begin
            v = order[i];
            j = i;
            while (j > 0 && precedes(v, order[j-1])) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = v;
        end
        k = 0;
        for (int i = 0; i < n; i++) begin
            p = order[i];
            while (k > 1 && turn_sign(stack_q[k-2], stack_q[k-1], p) <= 0) k--;
            stack_q[k++] = p;
        end
        t = k;
        for (int i = n - 2; i >= 0; i--) begin
            p = order[i];
            while (k > t && turn_sign(stack_q[k-2], stack_q[k-1], p) <= 0) k--;
            stack_q[k++] = p;
        end
        h = (k > 0) ? k - 1 : 0;
        for (int i = 0; i < n; i++) begin
            vtx_angle[i] = 0;
            for (int q = 0; q < h; q++) begin
                if (pt_x[stack_q[q]] == pt_x[i] && pt_y[stack_q[q]] == pt_y[i]) begin
                    vtx_angle[i] = ext_angle(i, stack_q[(q + h - 1) % h],
                                             stack_q[(q + 1) % h]);
                    break;
                end
            end
        end
    endfunction

    // note one accepted point; a closing point queues the shares of the set
    function void note_point(chas_pkg::t_coord x, chas_pkg::t_coord y, logic last);
        int              n;
        longint unsigned total, s;
        share_item_t     it;
        if (n_stored < 64) begin
            pt_x[n_stored] = x;
            pt_y[n_stored] = y;
            n_stored++;
        end
        if (!last) return;
        n = n_stored;
        n_stored = 0;
        if (n == 1) begin
            it.idx = 0; it.share = 32'h8000_0000; it.last = 1'b1;
            add_expected(it);
            return;
        end
        build_hull(n);
        total = 0;
        for (int i = 0; i < n; i++) total += vtx_angle[i];
        for (int i = 0; i < n; i++) begin
            s = 0;
            if (total != 0) begin
                s = ((longint'(vtx_angle[i]) << 31) + total / 2) / total;
                if (s > 64'h8000_0000) s = 64'h8000_0000;
            end
            it.idx = i[5:0]; it.share = s[31:0]; it.last = (i == n - 1);
            add_expected(it);
        end
    endfunction

    function void check_share(share_item_t got);
        share_item_t want;
        if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected share item idx=%0d share=%h last=%b",
                     $time, got.idx, got.share, got.last);
            return;
        end
        want = pending.pop_front();
        if (got.idx !== want.idx) begin
            errors++;
            $display("%0t: point_index expected %0d actual %0d", $time, want.idx, got.idx);
        end
        if (got.share !== want.share) begin
            errors++;
            $display("%0t: share (idx %0d) expected %h actual %h",
                     $time, want.idx, want.share, got.share);
        end
        if (got.last !== want.last) begin
            errors++;
            $display("%0t: last_share (idx %0d) expected %b actual %b",
                     $time, want.idx, want.last, got.last);
        end
    endfunction
endclass

module convex_hull_angle_share_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import chas_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   sent;
    bit   quiet;

    chas_pt_if pt();
    chas_sh_if sh();

    hull_share_board board;

    convex_hull_angle_share_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt),
        .o_sh    (sh)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    initial begin
        #6_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // share side: random stall bursts, none near the end
    initial begin
        int hold;
        hold = 0;
        sh.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                sh.ready = 1'b0;
                hold--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                sh.ready = 1'b0;
                hold = $urandom_range(0, 11);
            end else begin
                sh.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        share_item_t got;
        if (i_rst_n && sh.valid && sh.ready) begin
            got.idx = sh.point_index; got.share = sh.share; got.last = sh.last_share;
            board.check_share(got);
        end
    end

    task automatic send_point(t_coord x, t_coord y, logic last);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            pt.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        pt.point_x = x;
        pt.point_y = y;
        pt.last_point = last;
        pt.valid = 1'b1;
        do @(posedge i_clk); while (!pt.ready);
        board.note_point(x, y, last);
        sent++;
    endtask

    function automatic t_coord pick_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'(int'($urandom_range(0, 8)) - 4);
            2: case ($urandom_range(0, 2))
                   0: return t_coord'(-1048576);
                   1: return t_coord'(1048575);
                   default: return '0;
               endcase
            default: return t_coord'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic send_set(int n, int mode);
        int m;
        for (int i = 0; i < n; i++) begin
            m = (mode == 4) ? $urandom_range(0, 3) : mode;
            send_point(pick_coord(m), pick_coord(m), i == n - 1);
        end
    endtask

    initial begin
        board = new();
        sent = 0;
        quiet = 0;
        pt.valid = 1'b0;
        pt.point_x = '0;
        pt.point_y = '0;
        pt.last_point = 1'b0;
        i_rst_n = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // single point at the corner of the range
        send_point(-21'sd1048576, -21'sd1048576, 1'b1);
        // two points, full diagonal
        send_point(-21'sd1048576, 21'sd1048575, 1'b0);
        send_point(21'sd1048575, -21'sd1048576, 1'b1);
        // all coinciding
        send_point(21'sd7, -21'sd3, 1'b0);
        send_point(21'sd7, -21'sd3, 1'b0);
        send_point(21'sd7, -21'sd3, 1'b1);
        // collinear run plus an apex
        send_point(21'sd0, 21'sd0, 1'b0);
        send_point(21'sd1, 21'sd1, 1'b0);
        send_point(21'sd2, 21'sd2, 1'b0);
        send_point(21'sd0, 21'sd2, 1'b1);
        // extreme square with a center point and a repeated vertex
        send_point(-21'sd1048576, -21'sd1048576, 1'b0);
        send_point(21'sd1048575, -21'sd1048576, 1'b0);
        send_point(21'sd0, 21'sd0, 1'b0);
        send_point(21'sd1048575, 21'sd1048575, 1'b0);
        send_point(-21'sd1048576, 21'sd1048575, 1'b0);
        send_point(21'sd1048575, 21'sd1048575, 1'b1);
        // thin triangle, very small angle
        send_point(-21'sd1048576, 21'sd0, 1'b0);
        send_point(21'sd1048575, 21'sd1, 1'b0);
        send_point(21'sd1048575, 21'sd0, 1'b1);

        begin
            bit big_done;
            big_done = 0;
            while (sent < 220) begin
                quiet = (sent > 185);
                if (!big_done && sent > 70) begin
                    // overflow the store: the extra points are dropped
                    send_set(70, 4);
                    big_done = 1;
                end else begin
                    send_set($urandom_range(1, 10), $urandom_range(0, 4));
                end
            end
        end
        quiet = 1;
        @(negedge i_clk);
        pt.valid = 1'b0;
        pt.last_point = 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
